// File: hw/rtl/pidr_pkg.sv
// ----------------------------------------------------------------------------
// pidr_pkg
// Types and constants shared by the ramped-limit PID controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pidr_pkg;

    localparam int DATA_W  = 32;
    localparam int TIME_W  = 31;
    localparam int TICK_W  = 6;
    localparam int IDX_W   = 3;
    localparam int NUM_W   = 48;   // dividend width: 31 bit time shifted by 17
    localparam int DCNT_W  = 6;

    // IQ17 saturation thresholds
    localparam logic signed [31:0] EDGE17   = 32'sh7FFE_0000;  // 16383.0
    localparam logic signed [31:0] SUBST17  = 32'sh7D00_0000;  // 16000.0
    localparam logic signed [31:0] OUTSAT17 = 32'sh7FF8_0000;  // 16380.0
    localparam logic signed [63:0] EDGE8    = 64'sd4194048;    // 16383.0 in IQ8
    localparam logic [47:0]        RAMP_NUM = 48'd515375104;   // 0.03 IQ17 << 17

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INT_TIME    = 3'd1,
        REG_DER_TIME    = 3'd2,
        REG_SAMPLE_TIME = 3'd3,
        REG_UPPER       = 3'd4,
        REG_LOWER       = 3'd5,
        REG_RAMP_TIME   = 3'd6,
        REG_DER_ON_ERR  = 3'd7
    } reg_idx_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_PRESET,
        OP_LOAD,
        OP_DIV_GO,
        OP_DIV_RUN,
        OP_DIV_ST,
        OP_MUL_P,
        OP_POST_P,
        OP_MUL_ETS,
        OP_POST_ETS,
        OP_MUL_A,
        OP_POST_A,
        OP_MUL_KT,
        OP_POST_KT,
        OP_CLAMP_I,
        OP_MUL_DE,
        OP_POST_DE,
        OP_MUL_DS,
        OP_POST_DS,
        OP_MUL_DM,
        OP_POST_DM,
        OP_MUL_DK,
        OP_POST_DK,
        OP_SUM1,
        OP_SUM2,
        OP_RAMP,
        OP_FINAL
    } op_t;

    // which quotient the divider produces
    typedef enum logic [1:0] {
        DIV_TS_TI,
        DIV_TD_TI,
        DIV_TD_TS,
        DIV_STEP
    } div_sel_t;

    typedef struct packed {
        op_t      op;
        div_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic ti_zero;
        logic td_zero;
        logic der_on_err;
    } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pidr_if.sv
// ----------------------------------------------------------------------------
// pidr_if
// Channel interfaces: sample input, result output and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic               run;

    modport source (output valid, target, measured, run, input ready);
    modport sink   (input valid, target, measured, run, output ready);
endinterface

interface pidr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic signed [31:0] p_part;
    logic signed [31:0] i_part;
    logic signed [31:0] d_part;

    modport source (output valid, drive, p_part, i_part, d_part, input ready);
    modport sink   (input valid, drive, p_part, i_part, d_part, output ready);
endinterface

interface pidr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pidr_dp.sv
// ----------------------------------------------------------------------------
// pidr_dp
// Datapath: config registers, controller state, shared radix-2 divider,
// shared 32x32 multiplier with product register, saturation and limits.
// ----------------------------------------------------------------------------
`default_nettype none

module pidr_dp #(
    parameter int LIMIT_PERIOD = 30
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 capture,
    input  wire logic signed [31:0]   target,
    input  wire logic signed [31:0]   measured,
    input  wire pidr_pkg::cmd_t       cmd,
    output pidr_pkg::stat_t           stat,
    output logic signed [31:0]        drive,
    output logic signed [31:0]        p_part,
    output logic signed [31:0]        i_part,
    output logic signed [31:0]        d_part
);

    // configuration
    logic signed [31:0] kp_reg, upper_reg, lower_reg;
    logic [30:0]        ti_reg, td_reg, ts_reg, rt_reg;
    logic               doe_reg;

    // controller state
    logic signed [31:0] last_int_reg, last_err_reg, last_meas_reg;
    logic signed [31:0] dyn_up_reg, dyn_lo_reg;
    logic [pidr_pkg::TICK_W-1:0] tick_reg;

    // per-sample working registers
    logic signed [31:0] tgt_reg, meas_reg, err_reg, de_reg, dm_reg, nd_reg;
    logic signed [31:0] ts_ti_reg, td_ti_reg, td_ts_reg;
    logic               ti_wide_reg, ts_wide_reg;
    logic [30:0]        step_reg;
    logic signed [31:0] p_reg, i_reg, d_reg, t_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] drive_reg, p_out_reg, i_out_reg, d_out_reg;

    // divider
    logic [pidr_pkg::NUM_W-1:0]  quo_reg;
    logic [31:0]                 rem_reg;
    logic [30:0]                 den_reg;
    logic [pidr_pkg::DCNT_W-1:0] dcnt_reg;

    // saturating sum: beyond +-16383 becomes +-16000
    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s > 33'(pidr_pkg::EDGE17))
            return pidr_pkg::SUBST17;
        else if (s < -33'(pidr_pkg::EDGE17))
            return -pidr_pkg::SUBST17;
        else
            return s[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_dyn(input logic signed [31:0] v,
                                                     input logic signed [31:0] up,
                                                     input logic signed [31:0] lo);
        if (v >= up)
            return up;
        else if (v <= lo)
            return lo;
        else
            return v;
    endfunction

    // grow magnitude of a dynamic limit by one step towards its target
    function automatic logic signed [31:0] ramp_lim(input logic signed [31:0] dyn,
                                                    input logic signed [31:0] lim,
                                                    input logic [30:0]        step);
        logic [31:0] abs_d, abs_l;
        logic [32:0] grown;
        abs_d = dyn[31] ? 32'(-dyn) : 32'(dyn);
        abs_l = lim[31] ? 32'(-lim) : 32'(lim);
        grown = {1'b0, abs_d} + {2'b00, step};
        if (grown >= {1'b0, abs_l} || lim == 32'sd0 || step == 31'd0)
            return lim;
        else if (lim <= 32'sd0)
            return -$signed(grown[31:0]);
        else
            return $signed(grown[31:0]);
    endfunction

    // divider quotient, saturated, and the same quotient over four
    logic [31:0] qsat, q2sat;
    assign qsat  = (quo_reg[47:31] != '0) ? 32'h7FFF_FFFF : {1'b0, quo_reg[30:0]};
    assign q2sat = (quo_reg[47:33] != '0) ? 32'h7FFF_FFFF : {1'b0, quo_reg[32:2]};

    // one restoring step
    logic [31:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {rem_reg[30:0], quo_reg[47]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    // product post-processing
    logic signed [31:0] m17, r17, w17, sc_ti, sc_ts, m17_fix;
    logic signed [63:0] rnd, q8;
    always_comb
    begin
        m17 = prod_reg[48:17];
        rnd = (prod_reg + 64'sd65536) >>> 17;
        if (rnd > 64'sd2147483647)
            r17 = 32'sh7FFF_FFFF;
        else if (rnd < -64'sd2147483648)
            r17 = 32'sh8000_0000;
        else
            r17 = rnd[31:0];
        q8 = prod_reg >>> 24;
        if (q8 >= pidr_pkg::EDGE8)
            w17 = pidr_pkg::EDGE17;
        else if (q8 <= -pidr_pkg::EDGE8)
            w17 = -pidr_pkg::EDGE17;
        else
            w17 = prod_reg[46:15];
        sc_ti = ti_wide_reg ? w17 : r17;
        sc_ts = ts_wide_reg ? w17 : r17;
        // least step when the increment floors to zero
        if (m17 == 32'sd0 && err_reg != 32'sd0 && ts_ti_reg != 32'sd0)
            m17_fix = 32'sd1;
        else
            m17_fix = m17;
    end

    // multiplier operand selection
    logic signed [31:0] mul_a, mul_b;
    logic               mul_en;
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = kp_reg;
        mul_b  = err_reg;
        case (cmd.op)
            pidr_pkg::OP_MUL_P:   begin mul_a = kp_reg;  mul_b = err_reg;   end
            pidr_pkg::OP_MUL_ETS: begin mul_a = err_reg; mul_b = ts_ti_reg; end
            pidr_pkg::OP_MUL_A:   begin mul_a = dm_reg;  mul_b = td_ti_reg; end
            pidr_pkg::OP_MUL_KT:  begin mul_a = kp_reg;  mul_b = t_reg;     end
            pidr_pkg::OP_MUL_DE:  begin mul_a = de_reg;  mul_b = kp_reg;    end
            pidr_pkg::OP_MUL_DS:  begin mul_a = t_reg;   mul_b = td_ts_reg; end
            pidr_pkg::OP_MUL_DM:  begin mul_a = nd_reg;  mul_b = td_ts_reg; end
            pidr_pkg::OP_MUL_DK:  begin mul_a = t_reg;   mul_b = kp_reg;    end
            default:              mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

    // sum of the terms, saturated to +-16380
    logic signed [31:0] sum2;
    always_comb
    begin
        sum2 = add_sat(t_reg, d_reg);
        if (sum2 > pidr_pkg::OUTSAT17)
            sum2 = pidr_pkg::OUTSAT17;
        else if (sum2 < -pidr_pkg::OUTSAT17)
            sum2 = -pidr_pkg::OUTSAT17;
    end

    // configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= 32'sd131072;
            ti_reg        <= '0;
            td_reg        <= '0;
            ts_reg        <= 31'd131;
            upper_reg     <= '0;
            lower_reg     <= '0;
            rt_reg        <= '0;
            doe_reg       <= 1'b0;
            last_int_reg  <= '0;
            last_err_reg  <= '0;
            last_meas_reg <= '0;
            dyn_up_reg    <= '0;
            dyn_lo_reg    <= '0;
            tick_reg      <= pidr_pkg::TICK_W'(LIMIT_PERIOD);
        end
        else
        begin
            if (cfg_write)
            begin
                case (pidr_pkg::reg_idx_t'(cfg_index))
                    pidr_pkg::REG_PROP_GAIN:   kp_reg    <= cfg_data;
                    pidr_pkg::REG_INT_TIME:    ti_reg    <= cfg_data[30:0];
                    pidr_pkg::REG_DER_TIME:    td_reg    <= cfg_data[30:0];
                    pidr_pkg::REG_SAMPLE_TIME: ts_reg    <= cfg_data[30:0];
                    pidr_pkg::REG_UPPER:       upper_reg <= cfg_data;
                    pidr_pkg::REG_LOWER:       lower_reg <= cfg_data;
                    pidr_pkg::REG_RAMP_TIME:   rt_reg    <= cfg_data[30:0];
                    pidr_pkg::REG_DER_ON_ERR:  doe_reg   <= cfg_data[0];
                    default:                   ;
                endcase
            end
            case (cmd.op)
                pidr_pkg::OP_PRESET:
                    tick_reg <= pidr_pkg::TICK_W'(LIMIT_PERIOD);
                pidr_pkg::OP_RAMP:
                begin
                    if (tick_reg >= pidr_pkg::TICK_W'(LIMIT_PERIOD))
                    begin
                        tick_reg   <= '0;
                        dyn_up_reg <= ramp_lim(dyn_up_reg, upper_reg, step_reg);
                        dyn_lo_reg <= ramp_lim(dyn_lo_reg, lower_reg, step_reg);
                    end
                    else
                        tick_reg <= tick_reg + 1'b1;
                end
                pidr_pkg::OP_FINAL:
                begin
                    last_int_reg  <= i_reg;
                    last_err_reg  <= err_reg;
                    last_meas_reg <= meas_reg;
                end
                default: ;
            endcase
        end
    end

    // divider sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.op == pidr_pkg::OP_DIV_GO)
            dcnt_reg <= '0;
        else if (cmd.op == pidr_pkg::OP_DIV_RUN)
            dcnt_reg <= dcnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            tgt_reg  <= target;
            meas_reg <= measured;
        end
        case (cmd.op)
            pidr_pkg::OP_LOAD:
            begin
                err_reg <= tgt_reg - meas_reg;
                de_reg  <= tgt_reg - meas_reg - last_err_reg;
                dm_reg  <= meas_reg - last_meas_reg;
                nd_reg  <= last_meas_reg - meas_reg;
                i_reg   <= '0;
                d_reg   <= '0;
            end
            pidr_pkg::OP_DIV_GO:
            begin
                rem_reg <= '0;
                case (cmd.sel)
                    pidr_pkg::DIV_TS_TI: begin quo_reg <= {ts_reg, 17'd0}; den_reg <= ti_reg; end
                    pidr_pkg::DIV_TD_TI: begin quo_reg <= {td_reg, 17'd0}; den_reg <= ti_reg; end
                    pidr_pkg::DIV_TD_TS: begin quo_reg <= {td_reg, 17'd0}; den_reg <= ts_reg; end
                    default:             begin quo_reg <= pidr_pkg::RAMP_NUM; den_reg <= rt_reg; end
                endcase
            end
            pidr_pkg::OP_DIV_RUN:
            begin
                rem_reg <= rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                quo_reg <= {quo_reg[46:0], rem_ge};
            end
            pidr_pkg::OP_DIV_ST:
            begin
                case (cmd.sel)
                    pidr_pkg::DIV_TS_TI: ts_ti_reg <= qsat;
                    pidr_pkg::DIV_TD_TI:
                    begin
                        ti_wide_reg <= $signed(qsat) >= pidr_pkg::EDGE17;
                        td_ti_reg   <= ($signed(qsat) >= pidr_pkg::EDGE17) ? q2sat : qsat;
                    end
                    pidr_pkg::DIV_TD_TS:
                    begin
                        ts_wide_reg <= $signed(qsat) >= pidr_pkg::EDGE17;
                        td_ts_reg   <= ($signed(qsat) >= pidr_pkg::EDGE17) ? q2sat : qsat;
                    end
                    default: step_reg <= (rt_reg == '0) ? 31'd0 : qsat[30:0];
                endcase
            end
            pidr_pkg::OP_POST_P:   p_reg <= m17;
            pidr_pkg::OP_POST_ETS: t_reg <= m17_fix;
            pidr_pkg::OP_POST_A:   t_reg <= t_reg - sc_ti;
            pidr_pkg::OP_POST_KT:  t_reg <= add_sat(r17, last_int_reg);
            pidr_pkg::OP_CLAMP_I:  i_reg <= clamp_dyn(t_reg, dyn_up_reg, dyn_lo_reg);
            pidr_pkg::OP_POST_DE:  t_reg <= m17;
            pidr_pkg::OP_POST_DS:  d_reg <= sc_ts;
            pidr_pkg::OP_POST_DM:  t_reg <= sc_ts;
            pidr_pkg::OP_POST_DK:  d_reg <= r17;
            pidr_pkg::OP_SUM1:     t_reg <= add_sat(p_reg, i_reg);
            pidr_pkg::OP_SUM2:     t_reg <= sum2;
            pidr_pkg::OP_FINAL:
            begin
                drive_reg <= clamp_dyn(t_reg, dyn_up_reg, dyn_lo_reg);
                p_out_reg <= p_reg;
                i_out_reg <= i_reg;
                d_out_reg <= d_reg;
            end
            default: ;
        endcase
    end

    assign stat.div_last   = dcnt_reg == pidr_pkg::DCNT_W'(pidr_pkg::NUM_W - 1);
    assign stat.ti_zero    = ti_reg == '0;
    assign stat.td_zero    = td_reg == '0;
    assign stat.der_on_err = doe_reg;

    assign drive  = drive_reg;
    assign p_part = p_out_reg;
    assign i_part = i_out_reg;
    assign d_part = d_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pidr_ctrl.sv
// ----------------------------------------------------------------------------
// pidr_ctrl
// Sequencer: accepts a sample, steps the datapath through division,
// multiply and limit operations, and holds the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pidr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_run,
    output logic                 in_ready,
    output logic                 capture,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire pidr_pkg::stat_t stat,
    output pidr_pkg::cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_PRESET, S_LOAD, S_DGO, S_DRUN, S_DST,
        S_MUL_P, S_POST_P, S_MUL_ETS, S_POST_ETS, S_MUL_A, S_POST_A,
        S_MUL_KT, S_POST_KT, S_CLAMP_I, S_MUL_DE, S_POST_DE, S_MUL_DS,
        S_POST_DS, S_MUL_DM, S_POST_DM, S_MUL_DK, S_POST_DK,
        S_SUM1, S_SUM2, S_RAMP, S_WAIT, S_FINAL
    } state_t;

    state_t              state_reg, state_next;
    pidr_pkg::div_sel_t  sel_reg, sel_next;
    pidr_pkg::cmd_t      cmd_reg;
    logic                out_valid_reg;

    function automatic pidr_pkg::op_t op_of(input state_t s);
        case (s)
            S_PRESET:   return pidr_pkg::OP_PRESET;
            S_LOAD:     return pidr_pkg::OP_LOAD;
            S_DGO:      return pidr_pkg::OP_DIV_GO;
            S_DRUN:     return pidr_pkg::OP_DIV_RUN;
            S_DST:      return pidr_pkg::OP_DIV_ST;
            S_MUL_P:    return pidr_pkg::OP_MUL_P;
            S_POST_P:   return pidr_pkg::OP_POST_P;
            S_MUL_ETS:  return pidr_pkg::OP_MUL_ETS;
            S_POST_ETS: return pidr_pkg::OP_POST_ETS;
            S_MUL_A:    return pidr_pkg::OP_MUL_A;
            S_POST_A:   return pidr_pkg::OP_POST_A;
            S_MUL_KT:   return pidr_pkg::OP_MUL_KT;
            S_POST_KT:  return pidr_pkg::OP_POST_KT;
            S_CLAMP_I:  return pidr_pkg::OP_CLAMP_I;
            S_MUL_DE:   return pidr_pkg::OP_MUL_DE;
            S_POST_DE:  return pidr_pkg::OP_POST_DE;
            S_MUL_DS:   return pidr_pkg::OP_MUL_DS;
            S_POST_DS:  return pidr_pkg::OP_POST_DS;
            S_MUL_DM:   return pidr_pkg::OP_MUL_DM;
            S_POST_DM:  return pidr_pkg::OP_POST_DM;
            S_MUL_DK:   return pidr_pkg::OP_MUL_DK;
            S_POST_DK:  return pidr_pkg::OP_POST_DK;
            S_SUM1:     return pidr_pkg::OP_SUM1;
            S_SUM2:     return pidr_pkg::OP_SUM2;
            S_RAMP:     return pidr_pkg::OP_RAMP;
            S_FINAL:    return pidr_pkg::OP_FINAL;
            default:    return pidr_pkg::OP_NOP;
        endcase
    endfunction

    assign in_ready = state_reg == S_IDLE;
    assign capture  = in_valid && in_ready;

    // derivative branch entry
    state_t d_entry;
    assign d_entry = stat.td_zero ? S_SUM1 : (stat.der_on_err ? S_MUL_DE : S_MUL_DM);

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            S_IDLE:
                if (capture)
                begin
                    state_next = in_run ? S_LOAD : S_PRESET;
                    sel_next   = pidr_pkg::DIV_TS_TI;
                end
            S_PRESET:   state_next = S_IDLE;
            S_LOAD:     state_next = S_DGO;
            S_DGO:      state_next = S_DRUN;
            S_DRUN:     if (stat.div_last) state_next = S_DST;
            S_DST:
                case (sel_reg)
                    pidr_pkg::DIV_TS_TI: begin sel_next = pidr_pkg::DIV_TD_TI; state_next = S_DGO; end
                    pidr_pkg::DIV_TD_TI: begin sel_next = pidr_pkg::DIV_TD_TS; state_next = S_DGO; end
                    pidr_pkg::DIV_TD_TS: begin sel_next = pidr_pkg::DIV_STEP;  state_next = S_DGO; end
                    default:             state_next = S_MUL_P;
                endcase
            S_MUL_P:    state_next = S_POST_P;
            S_POST_P:   state_next = stat.ti_zero ? d_entry : S_MUL_ETS;
            S_MUL_ETS:  state_next = S_POST_ETS;
            S_POST_ETS: state_next = stat.der_on_err ? S_MUL_KT : S_MUL_A;
            S_MUL_A:    state_next = S_POST_A;
            S_POST_A:   state_next = S_MUL_KT;
            S_MUL_KT:   state_next = S_POST_KT;
            S_POST_KT:  state_next = S_CLAMP_I;
            S_CLAMP_I:  state_next = d_entry;
            S_MUL_DE:   state_next = S_POST_DE;
            S_POST_DE:  state_next = S_MUL_DS;
            S_MUL_DS:   state_next = S_POST_DS;
            S_POST_DS:  state_next = S_SUM1;
            S_MUL_DM:   state_next = S_POST_DM;
            S_POST_DM:  state_next = S_MUL_DK;
            S_MUL_DK:   state_next = S_POST_DK;
            S_POST_DK:  state_next = S_SUM1;
            S_SUM1:     state_next = S_SUM2;
            S_SUM2:     state_next = S_RAMP;
            S_RAMP:     state_next = S_WAIT;
            S_WAIT:     if (!out_valid_reg || out_ready) state_next = S_FINAL;
            S_FINAL:    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // state, command and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= pidr_pkg::DIV_TS_TI;
            cmd_reg       <= '{op: pidr_pkg::OP_NOP, sel: pidr_pkg::DIV_TS_TI};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            cmd_reg.op  <= op_of(state_next);
            cmd_reg.sel <= sel_next;
            if (state_reg == S_FINAL)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign cmd       = cmd_reg;
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // a stopped sample never yields a result
    a_no_result_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        capture && !in_run |=> !$rose(out_valid_reg))
        else $error("result raised for stopped sample");

    // results only appear from the commit step
    a_rise_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINAL))
        else $error("result valid without commit");

    // commit never overwrites a pending result
    a_final_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINAL |-> !out_valid_reg)
        else $error("commit over pending result");

    // divider iterates while waiting for quotient
    a_div_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRUN |-> cmd_reg.op == pidr_pkg::OP_DIV_RUN)
        else $error("divider not stepping");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/pid_with_ramped_output_limits.sv
// From sample acceptance to result valid the block runs four 48-step
// quotients on the shared one-bit-per-cycle divider plus its load,
// multiply, sum and limit steps, and takes longer while an earlier
// result waits. One sample at a time; a stopped sample only presets the
// limit tick. A finished result waits in its output register. Reset
// (rst_n, async low) restores default gains, clears history and limits.
// ----------------------------------------------------------------------------
// pid_with_ramped_output_limits
// PID controller with derivative on error or measurement and dynamic
// output limits that ramp towards the configured limits.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_with_ramped_output_limits #(
    parameter int LIMIT_PERIOD = 30
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pidr_in_if.sink     sample,
    pidr_out_if.source  result,
    pidr_cfg_if.sink    cfg
);

    pidr_pkg::cmd_t  cmd;
    pidr_pkg::stat_t stat;
    logic            capture;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    pidr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_run    (sample.run),
        .in_ready  (sample.ready),
        .capture   (capture),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pidr_dp #(
        .LIMIT_PERIOD (LIMIT_PERIOD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .capture   (capture),
        .target    (sample.target),
        .measured  (sample.measured),
        .cmd       (cmd),
        .stat      (stat),
        .drive     (result.drive),
        .p_part    (result.p_part),
        .i_part    (result.i_part),
        .d_part    (result.d_part)
    );

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ramped-limit PID controller. A bit-exact
// predictor of the control law runs beside the block; every returned result
// is checked field by field against the queue of predicted outputs while
// both channels idle and stall at random across several load phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int LIMIT_PERIOD = 30;
    localparam int SETTLE_CYC   = 300;    // block latency plus margin
    localparam int WDOG_LIMIT   = 4000;   // cycles with no request moved
    localparam int ONE17        = 131072;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] p_part;
        logic signed [31:0] i_part;
        logic signed [31:0] d_part;
    } ctrl_out_t;

    logic clk;
    logic rst_n;

    pidr_in_if  sample_ch ();
    pidr_out_if result_ch ();
    pidr_cfg_if cfg_ch ();

    pid_with_ramped_output_limits #(.LIMIT_PERIOD(LIMIT_PERIOD)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor copy of registers and controller state
    int          kp;
    int unsigned ti, td, ts, ramp_t;
    int          up_lim, lo_lim;
    bit          d_on_err;
    int          hist_int, hist_err, hist_meas, dyn_up, dyn_lo;
    int unsigned tick;

    ctrl_out_t   pending_q[$];
    int          fails;
    int          in_idle, out_stall, hold_cnt, idle_cyc;

    function automatic int sat32(longint x);
        if (x > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(x);
    endfunction

    // floor product, wraps
    function automatic int fmul(int a, int b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return int'(prod >>> 17);
    endfunction

    // rounded product, saturates
    function automatic int rmul(int a, int b);
        return sat32((longint'(a) * longint'(b) + 65536) >>> 17);
    endfunction

    function automatic int qdiv(longint unsigned num, int unsigned den);
        longint unsigned q;
        if (den == 0)
            return 32'h7FFF_FFFF;
        q = num / longint'(den);
        if (q > 64'd2147483647)
            return 32'h7FFF_FFFF;
        return int'(q);
    endfunction

    // product with a ratio held in IQ15
    function automatic int wmul(int a, int b);
        longint prod;
        longint q8;
        prod = longint'(a) * longint'(b);
        q8   = prod >>> 24;
        if (q8 >= longint'(16383) * 256)
            return 16383 * ONE17;
        if (q8 <= -(longint'(16383) * 256))
            return -(16383 * ONE17);
        return int'(prod >>> 15);
    endfunction

    function automatic int sadd(int a, int b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(16383) * ONE17)
            return 16000 * ONE17;
        if (s < -(longint'(16383) * ONE17))
            return -(16000 * ONE17);
        return int'(s);
    endfunction

    function automatic int clamp_dyn(int v);
        if (v >= dyn_up)
            return dyn_up;
        if (v <= dyn_lo)
            return dyn_lo;
        return v;
    endfunction

    function automatic longint mag(int v);
        return (v < 0) ? -longint'(v) : longint'(v);
    endfunction

    function automatic int ramp_lim(int dyn, int lim, int step);
        longint grown;
        grown = mag(dyn) + longint'(step);
        if (grown >= mag(lim) || lim == 0 || step == 0)
            return lim;
        return (lim <= 0) ? int'(-grown) : int'(grown);
    endfunction

    // one sample of the control law; returns 1 when a result follows
    function automatic bit pid_sample(int tgt, int meas, bit run, output ctrl_out_t r);
        int ts_ti, td_ti, td_ts, err, p, i, d, t, a, step, pre;
        bit ti_wide, ts_wide;
        ts_ti = 0; td_ti = 0; i = 0; d = 0; step = 0;
        ti_wide = 0; ts_wide = 0;
        r = '0;
        if (!run)
        begin
            tick = LIMIT_PERIOD;
            return 0;
        end
        if (ti != 0)
        begin
            ts_ti = qdiv(longint'(ts) << 17, ti);
            td_ti = qdiv(longint'(td) << 17, ti);
            if (td_ti >= 16383 * ONE17)
            begin
                td_ti   = qdiv(longint'(td) << 15, ti);
                ti_wide = 1;
            end
        end
        td_ts = qdiv(longint'(td) << 17, ts);
        if (td_ts >= 16383 * ONE17)
        begin
            td_ts   = qdiv(longint'(td) << 15, ts);
            ts_wide = 1;
        end
        err = tgt - meas;
        p   = fmul(kp, err);
        if (ti != 0)
        begin
            t = fmul(err, ts_ti);
            // least integral step when the increment floors to zero
            if (t == 0 && err != 0 && ts_ti != 0)
                t = 1;
            if (!d_on_err)
            begin
                a = meas - hist_meas;
                a = ti_wide ? wmul(a, td_ti) : rmul(a, td_ti);
                t = t - a;
            end
            t = rmul(kp, t);
            t = sadd(t, hist_int);
            i = clamp_dyn(t);
        end
        if (td != 0)
        begin
            if (d_on_err)
            begin
                t = fmul(err - hist_err, kp);
                d = ts_wide ? wmul(t, td_ts) : rmul(t, td_ts);
            end
            else
            begin
                t = hist_meas - meas;
                t = ts_wide ? wmul(t, td_ts) : rmul(t, td_ts);
                d = rmul(t, kp);
            end
        end
        pre = sadd(sadd(p, i), d);
        if (pre > 16380 * ONE17)
            pre = 16380 * ONE17;
        if (pre < -(16380 * ONE17))
            pre = -(16380 * ONE17);
        if (ramp_t != 0)
            step = qdiv(longint'(3932) << 17, ramp_t);
        if (tick >= LIMIT_PERIOD)
        begin
            tick   = 0;
            dyn_up = ramp_lim(dyn_up, up_lim, step);
            dyn_lo = ramp_lim(dyn_lo, lo_lim, step);
        end
        else
            tick = (tick + 1) & 63;
        pre       = clamp_dyn(pre);
        hist_int  = i;
        hist_err  = err;
        hist_meas = meas;
        r.drive  = pre;
        r.p_part = p;
        r.i_part = i;
        r.d_part = d;
        return 1;
    endfunction

    // one register write request
    task automatic write_reg(pidr_pkg::reg_idx_t idx, logic [31:0] val);
        logic rdy;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
        begin
            @(negedge clk) rdy = cfg_ch.ready;
            @(posedge clk);
        end while (!rdy);
        case (idx)
            pidr_pkg::REG_PROP_GAIN:   kp       = val;
            pidr_pkg::REG_INT_TIME:    ti       = val & 32'h7FFF_FFFF;
            pidr_pkg::REG_DER_TIME:    td       = val & 32'h7FFF_FFFF;
            pidr_pkg::REG_SAMPLE_TIME: ts       = val & 32'h7FFF_FFFF;
            pidr_pkg::REG_UPPER:       up_lim   = val;
            pidr_pkg::REG_LOWER:       lo_lim   = val;
            pidr_pkg::REG_RAMP_TIME:   ramp_t   = val & 32'h7FFF_FFFF;
            pidr_pkg::REG_DER_ON_ERR:  d_on_err = val[0];
            default: ;
        endcase
    endtask

    task automatic set_all(int g, int i_t, int d_t, int s_t, int u, int l, int r_t, bit doe);
        write_reg(pidr_pkg::REG_PROP_GAIN, g);
        write_reg(pidr_pkg::REG_INT_TIME, i_t);
        write_reg(pidr_pkg::REG_DER_TIME, d_t);
        write_reg(pidr_pkg::REG_SAMPLE_TIME, s_t);
        write_reg(pidr_pkg::REG_UPPER, u);
        write_reg(pidr_pkg::REG_LOWER, l);
        write_reg(pidr_pkg::REG_RAMP_TIME, r_t);
        write_reg(pidr_pkg::REG_DER_ON_ERR, doe);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // one sample request, valid left high for a following request
    task automatic send_sample(int tgt, int meas, bit run);
        logic rdy;
        ctrl_out_t r;
        while ($urandom_range(99) < in_idle)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.target   <= tgt;
        sample_ch.measured <= meas;
        sample_ch.run      <= run;
        do
        begin
            @(negedge clk) rdy = sample_ch.ready;
            @(posedge clk);
        end while (!rdy);
        if (pid_sample(tgt, meas, run, r))
            pending_q.push_back(r);
    endtask

    // idle the input and wait for the block to go quiet
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic int rand_sig();
        logic [31:0] ext [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        case ($urandom_range(3))
            0: return $urandom;
            1: return int'($urandom_range(1 << 21)) - (1 << 20);
            2: return int'($urandom_range(1 << 27)) - (1 << 26);
            default: return ext[$urandom_range(3)];
        endcase
    endfunction

    function automatic int rand_time();
        case ($urandom_range(4))
            0: return 0;
            1: return $urandom_range(1, 1 << 18);
            2: return $urandom & 32'h7FFF_FFFF;
            3: return 32'h7FFF_FFFF;
            default: return $urandom_range(1 << 16, 1 << 22);
        endcase
    endfunction

    task automatic rand_config();
        int g, u, l;
        case ($urandom_range(3))
            0: g = $urandom;
            1: g = 0;
            default: g = int'($urandom_range(1 << 20)) - (1 << 19);
        endcase
        case ($urandom_range(3))
            0: begin u = $urandom; l = $urandom; end   // crossed or extreme
            1: begin u = 32'h7FFF_FFFF; l = 32'h8000_0000; end
            default: begin u = $urandom_range(1 << 27); l = -int'($urandom_range(1 << 27)); end
        endcase
        set_all(g, rand_time(), rand_time(),
                ($urandom_range(3) == 0) ? (int'($urandom) & 32'h7FFF_FFFF)
                                         : int'($urandom_range(1, 1 << 17)),
                u, l, ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 2000),
                $urandom_range(1));
    endtask

    // ---- tests ----

    task automatic test_defaults();
        send_sample(10 * ONE17, 2 * ONE17, 1);
        send_sample(-ONE17, ONE17, 1);
        send_sample(0, 0, 0);
        drain();
    endtask

    task automatic test_extremes();
        set_all(ONE17, ONE17, 1311, 131, 100 * ONE17, -100 * ONE17, 0, 1);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_sample(0, 32'hFFFF_FFFF, 1);
        send_sample(1, 0, 1);          // increment floors to zero
        send_sample(0, 0, 0);          // stopped sample
        send_sample(5 * ONE17, ONE17, 1);
        drain();
        // ratios beyond range switch format
        set_all(32'h8000_0000, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send_sample(ONE17, -ONE17, 1);
        send_sample(32'h7FFF_FFFF, 0, 1);
        send_sample(-ONE17, 32'h8000_0000, 1);
        drain();
        write_reg(pidr_pkg::REG_DER_ON_ERR, 1);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        send_sample(ONE17, -ONE17, 1);
        send_sample(32'h8000_0000, ONE17, 1);
        drain();
        // zero sample time, crossed limits
        set_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 3, 0, -ONE17, ONE17, 32'h7FFF_FFFF, 0);
        send_sample(3 * ONE17, 0, 1);
        send_sample(-3 * ONE17, ONE17, 1);
        send_sample(0, 0, 1);
        drain();
    endtask

    task automatic test_ramp();
        set_all(2 * ONE17, ONE17, 0, 131, 50 * ONE17, -50 * ONE17, 1, 1);
        repeat (100)
            send_sample(rand_sig(), rand_sig(), $urandom_range(19) != 0);
        drain();
    endtask

    task automatic test_backpressure();
        hold_cnt = 600;
        repeat (15)
            send_sample(rand_sig(), rand_sig(), 1);
        drain();
    endtask

    task automatic test_random(int n_in, int n_out);
        in_idle   = n_in;
        out_stall = n_out;
        rand_config();
        repeat (250)
        begin
            if ($urandom_range(59) == 0)
            begin
                drain();
                rand_config();
            end
            send_sample(rand_sig(), rand_sig(), $urandom_range(9) != 0);
        end
        drain();
    endtask

    // receiver ready
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= out_stall);
    end

    // result check and watchdog
    always @(negedge clk)
    begin
        ctrl_out_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result drive=%0d", result_ch.drive);
            end
            else
            begin
                want = pending_q.pop_front();
                if (want.drive !== result_ch.drive || want.p_part !== result_ch.p_part ||
                    want.i_part !== result_ch.i_part || want.d_part !== result_ch.d_part)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch exp d/p/i/d %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 want.drive, want.p_part, want.i_part, want.d_part,
                                 result_ch.drive, result_ch.p_part, result_ch.i_part,
                                 result_ch.d_part);
                end
            end
        end
        if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cyc <= 0;
        else if (idle_cyc >= WDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else
            idle_cyc <= idle_cyc + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.target = '0;
        sample_ch.measured = '0;
        sample_ch.run = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        fails = 0; in_idle = 0; out_stall = 0; hold_cnt = 0; idle_cyc = 0;
        kp = ONE17; ti = 0; td = 0; ts = 131; up_lim = 0; lo_lim = 0;
        ramp_t = 0; d_on_err = 0;
        hist_int = 0; hist_err = 0; hist_meas = 0; dyn_up = 0; dyn_lo = 0;
        tick = LIMIT_PERIOD;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_extremes();
        test_ramp();
        test_backpressure();
        test_random(0, 0);
        test_random(80, 0);
        test_random(0, 80);
        test_random(30, 30);

        if (fails == 0 && pending_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
